// ===== hw/rtl/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic report scheduler package
// Field widths, scan controller states and the held report record.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int SENSOR_W = 2;
  localparam int SLOT_W   = 5;
  localparam int PERIOD_W = 32;
  localparam int TICK_W   = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } prs_state_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
  } prs_rec_t;

endpackage

// ===== hw/rtl/periodic_report_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Periodic report scheduler core
// Holds a period and a last-report tick per sensor slot in two RAMs and
// scans all slots on every tick, emitting a report beat for each due slot.
//
//   Channel  Ports                               Direction  Beat
//   in       in_valid / in_ready / in_*          sink       set period or tick
//   out      out_valid / out_ready / out_*       source     ack or report
//
// A set-period beat yields one acknowledgement.
// A tick beat is accepted, then each slot is read from both RAMs and judged;
// after the final slot is judged the scan closes, and the drain state sends
// the last held report. Output stalls can hold the scan and the drain.
// Reset clears the valid bits of both tables and the tick counter at once.
// Each due slot waits in a holding register until it is sent out.
// ----------------------------------------------------------------------------
module periodic_report_scheduler_core
  import prs_pkg::*;
#(
  parameter int SENSOR_COUNT = 3,
  parameter int SLOT_COUNT   = 21
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [SENSOR_W-1:0] in_sensor,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [PERIOD_W-1:0] in_period,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_is_report,
  output logic                out_accepted,
  output logic [SENSOR_W-1:0] out_sensor,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [PERIOD_W-1:0] out_period,
  output logic                out_last
);

  localparam int PAIR_COUNT = SENSOR_COUNT * SLOT_COUNT;
  localparam int ADDR_W     = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
  localparam int CNT_W      = $clog2(PAIR_COUNT + 1);

  prs_state_t state_r, state_nxt;

  logic [PAIR_COUNT-1:0] pvalid_r, pvalid_nxt;
  logic [PAIR_COUNT-1:0] lvalid_r, lvalid_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;
  logic [CNT_W-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic                  ev_valid_r, ev_valid_nxt;
  logic [ADDR_W-1:0]     ev_idx_r, ev_idx_nxt;
  logic [SENSOR_W-1:0]   ev_sensor_r, ev_sensor_nxt;
  logic [SLOT_W-1:0]     ev_slot_r, ev_slot_nxt;
  logic                  pv_q_r, pv_q_nxt;
  logic                  lv_q_r, lv_q_nxt;
  logic                  held_v_r, held_v_nxt;
  prs_rec_t              held_r, held_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_is_report_r, out_is_report_nxt;
  logic                  out_accepted_r, out_accepted_nxt;
  prs_rec_t              out_rec_r, out_rec_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_fire;
  logic                  out_free;
  logic                  set_ok;
  logic [ADDR_W-1:0]     wr_idx;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  rd_done;
  logic                  rd_en;
  logic [PERIOD_W-1:0]   per_rd;
  logic [TICK_W-1:0]     last_rd;
  logic [PERIOD_W-1:0]   p_eff;
  logic [TICK_W-1:0]     l_eff;
  logic [TICK_W-1:0]     elapsed;
  logic                  due;
  logic                  stall;
  logic                  advance;
  logic                  scan_end;
  logic                  drain_done;
  logic                  per_we;
  logic                  last_we;

  assign out_free = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign set_ok   = ({1'b0, in_sensor} < (SENSOR_W + 1)'(SENSOR_COUNT)) &&
                    ({1'b0, in_slot} < (SLOT_W + 1)'(SLOT_COUNT));
  assign wr_idx   = ADDR_W'(32'(in_sensor) * 32'(SLOT_COUNT) + 32'(in_slot));
  assign rd_addr  = rd_cnt_r[ADDR_W-1:0];
  assign rd_done  = (rd_cnt_r == CNT_W'(PAIR_COUNT));

  assign p_eff    = pv_q_r ? per_rd : '0;
  assign l_eff    = lv_q_r ? last_rd : '0;
  assign elapsed  = tick_r - l_eff;
  assign due      = ev_valid_r && (p_eff != '0) && (elapsed >= p_eff);
  assign stall    = due && held_v_r && !out_free;
  assign advance  = (state_r == ST_SCAN) && !stall;
  assign rd_en    = advance && !rd_done;
  assign scan_end = (state_r == ST_SCAN) && rd_done && !ev_valid_r;
  assign drain_done = (state_r == ST_DRAIN) && (!held_v_r || out_free);

  assign per_we   = in_fire && !in_kind && set_ok;
  assign last_we  = due && !stall;

  prs_ram #(
    .WIDTH(PERIOD_W),
    .DEPTH(PAIR_COUNT)
  ) u_period_ram (
    .clk  (clk),
    .we   (per_we),
    .waddr(wr_idx),
    .wdata(in_period),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(per_rd)
  );

  prs_ram #(
    .WIDTH(TICK_W),
    .DEPTH(PAIR_COUNT)
  ) u_last_ram (
    .clk  (clk),
    .we   (last_we),
    .waddr(ev_idx_r),
    .wdata(tick_r),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(last_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_kind) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready          = (state_r == ST_IDLE) && out_free;
    pvalid_nxt        = pvalid_r;
    lvalid_nxt        = lvalid_r;
    tick_nxt          = tick_r;
    rd_cnt_nxt        = rd_cnt_r;
    ev_valid_nxt      = ev_valid_r;
    ev_idx_nxt        = ev_idx_r;
    ev_sensor_nxt     = ev_sensor_r;
    ev_slot_nxt       = ev_slot_r;
    pv_q_nxt          = pv_q_r;
    lv_q_nxt          = lv_q_r;
    held_v_nxt        = held_v_r;
    held_nxt          = held_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_is_report_nxt = out_is_report_r;
    out_accepted_nxt  = out_accepted_r;
    out_rec_nxt       = out_rec_r;
    out_last_nxt      = out_last_r;

    if (per_we) begin
      pvalid_nxt[wr_idx] = 1'b1;
    end
    if (last_we) begin
      lvalid_nxt[ev_idx_r] = 1'b1;
    end

    if (in_fire && !in_kind) begin
      out_valid_nxt      = 1'b1;
      out_is_report_nxt  = 1'b0;
      out_accepted_nxt   = set_ok;
      out_rec_nxt.sensor = in_sensor;
      out_rec_nxt.slot   = in_slot;
      out_rec_nxt.period = set_ok ? in_period : '0;
      out_last_nxt       = 1'b1;
    end

    if (in_fire && in_kind) begin
      rd_cnt_nxt    = '0;
      ev_valid_nxt  = 1'b0;
      ev_idx_nxt    = '0;
      ev_sensor_nxt = '0;
      ev_slot_nxt   = '0;
    end

    if (advance) begin
      if (rd_en) begin
        rd_cnt_nxt = rd_cnt_r + 1'b1;
        pv_q_nxt   = pvalid_r[rd_addr];
        lv_q_nxt   = lvalid_r[rd_addr];
      end
      ev_valid_nxt = rd_en;
      if (ev_valid_r) begin
        ev_idx_nxt = ev_idx_r + 1'b1;
        if (ev_slot_r == SLOT_W'(SLOT_COUNT - 1)) begin
          ev_slot_nxt   = '0;
          ev_sensor_nxt = ev_sensor_r + 1'b1;
        end else begin
          ev_slot_nxt = ev_slot_r + 1'b1;
        end
      end
      if (due) begin
        if (held_v_r) begin
          out_valid_nxt     = 1'b1;
          out_is_report_nxt = 1'b1;
          out_accepted_nxt  = 1'b1;
          out_rec_nxt       = held_r;
          out_last_nxt      = 1'b0;
        end
        held_v_nxt    = 1'b1;
        held_nxt.sensor = ev_sensor_r;
        held_nxt.slot   = ev_slot_r;
        held_nxt.period = p_eff;
      end
    end

    if (drain_done) begin
      tick_nxt = tick_r + 1'b1;
      if (held_v_r) begin
        out_valid_nxt     = 1'b1;
        out_is_report_nxt = 1'b1;
        out_accepted_nxt  = 1'b1;
        out_rec_nxt       = held_r;
        out_last_nxt      = 1'b1;
        held_v_nxt        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pvalid_r    <= '0;
      lvalid_r    <= '0;
      tick_r      <= '0;
      rd_cnt_r    <= '0;
      ev_valid_r  <= 1'b0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pvalid_r    <= pvalid_nxt;
      lvalid_r    <= lvalid_nxt;
      tick_r      <= tick_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      ev_valid_r  <= ev_valid_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r        <= ev_idx_nxt;
    ev_sensor_r     <= ev_sensor_nxt;
    ev_slot_r       <= ev_slot_nxt;
    pv_q_r          <= pv_q_nxt;
    lv_q_r          <= lv_q_nxt;
    held_r          <= held_nxt;
    out_is_report_r <= out_is_report_nxt;
    out_accepted_r  <= out_accepted_nxt;
    out_rec_r       <= out_rec_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_is_report = out_is_report_r;
  assign out_accepted  = out_accepted_r;
  assign out_sensor    = out_rec_r.sensor;
  assign out_slot      = out_rec_r.slot;
  assign out_period    = out_rec_r.period;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !held_v_r)
    else $error("held report left over outside a scan");

  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid_r |-> (state_r == ST_SCAN))
    else $error("slot evaluation outside a scan");

  a_tick_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(tick_r) |-> $past(state_r == ST_DRAIN))
    else $error("tick counter moved outside the end of a scan");

  a_rd_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cnt_r <= CNT_W'(PAIR_COUNT))
    else $error("scan read counter ran past the table");
`endif

endmodule

// ===== hw/rtl/prs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module prs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
